>>> rtl/grouped_fifo_queue_assert.svh
// Assertion macros used by the queue core
`ifndef GROUPED_FIFO_QUEUE_ASSERT_SVH
`define GROUPED_FIFO_QUEUE_ASSERT_SVH
// Check an implication on every clock edge outside reset
`define GFQ_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition holds on every clock edge outside reset
`define GFQ_ASSERT_ALWAYS(label, clk_s, rst_s, cond) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) \
    else $error("assertion failed");
`endif

>>> rtl/gfq_pkg.sv
// ---------------------------------------------------------------------------
// gfq_pkg
// Types and constants of the grouped FIFO queue.
// ---------------------------------------------------------------------------
`default_nettype none
package gfq_pkg;
  localparam int GroupCount   = 64;
  localparam int ElementSpace = 1024;
  localparam int NodeCapacity = 1024;
  localparam int GW = $clog2(GroupCount);
  localparam int EW = $clog2(ElementSpace);
  localparam int NW = $clog2(NodeCapacity);

  typedef enum logic [1:0] {
    CMD_BIND = 2'd0, CMD_ENQ = 2'd1, CMD_DEQ = 2'd2, CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_UNASSIGNED = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]    command;
    logic [EW-1:0] element;
    logic [GW-1:0] group_id;
  } in_word_t;

  typedef struct packed {
    logic [EW-1:0] out_element;
    logic          out_valid;
    logic [1:0]    status;
  } out_word_t;
endpackage
`default_nettype wire

>>> rtl/gfq_if.sv
// ---------------------------------------------------------------------------
// gfq_if
// Valid/ready channel carrying one packed word.
// ---------------------------------------------------------------------------
`default_nettype none
interface gfq_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/gfq_map.sv
// ---------------------------------------------------------------------------
// gfq_map
// Element-to-group table with clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none
module gfq_map
  import gfq_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [EW-1:0] rd_addr,
  output logic [GW:0]        rd_data,
  input  wire logic          wr_en,
  input  wire logic [EW-1:0] wr_addr,
  input  wire logic [GW:0]   wr_data,
  output logic               busy
);
  logic [GW:0] mem [ElementSpace];
  logic [EW:0] clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (!clr[EW]) begin
      clr <= clr + 1'b1;
    end
  end
  assign busy = !clr[EW];

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr[EW-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/gfq_core.sv
// ---------------------------------------------------------------------------
// gfq_core
// Command sequencer over node, free-list and group memories.
// ---------------------------------------------------------------------------
`default_nettype none
module gfq_core
  import gfq_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire in_word_t      cmd_word,
  input  wire logic [GW:0]   map_data,
  output out_word_t          res,
  output logic               done
);
  `include "grouped_fifo_queue_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_GRP = 4'b0010, S_NODE = 4'b0100, S_FIN = 4'b1000
  } state_t;

  state_t state;
  in_word_t cw;
  logic [EW-1:0] node_value [NodeCapacity];
  logic [NW-1:0] node_next  [NodeCapacity];
  logic [NW-1:0] free_stack [NodeCapacity];
  logic [NW-1:0] head [GroupCount];
  logic [NW-1:0] tail [GroupCount];
  logic [GW-1:0] order [GroupCount];
  logic [GroupCount-1:0] active;
  logic [NW:0] free_count;
  logic [NW:0] init_ptr;
  logic [GW-1:0] oh, ot;
  logic [GW:0] ocount;
  logic [EW-1:0] rd_value;
  logic [NW-1:0] rd_next, rd_free, rd_head, rd_tail;
  logic [GW-1:0] rd_order;
  logic [GW-1:0] g;
  logic enq_ok, deq_ok, deq_last;
  out_word_t res_next;

  // Group of the command: front of the order for dequeue, map entry otherwise
  assign g = (cw.command == CMD_DEQ) ? rd_order : map_data[GW-1:0];
  assign enq_ok = (cw.command == CMD_ENQ) && map_data[GW] && (free_count != '0);
  assign deq_ok = (cw.command == CMD_DEQ) && (ocount != '0);
  assign deq_last = (rd_head == rd_tail);

  always_comb begin
    res_next = '0;
    res_next.status = ST_OK;
    case (cw.command)
      CMD_ENQ: begin
        if (!map_data[GW]) begin
          res_next.status = ST_UNASSIGNED;
        end else if (free_count == '0) begin
          res_next.status = ST_FULL;
        end
      end
      CMD_DEQ: begin
        if (ocount == '0) begin
          res_next.status = ST_EMPTY;
        end else begin
          res_next.out_element = rd_value;
          res_next.out_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Order FIFO: read the front while idle, append a newly active group
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      rd_order <= order[oh];
    end
    if (state == S_FIN && enq_ok && !active[g]) begin
      order[ot] <= g;
    end
  end

  // Free stack: loaded with every node index after reset, top read while idle
  always_ff @(posedge clk) begin
    if (!init_ptr[NW]) begin
      free_stack[init_ptr[NW-1:0]] <= init_ptr[NW-1:0];
    end else if (state == S_FIN && deq_ok) begin
      free_stack[free_count[NW-1:0]] <= rd_head;
    end
    if (state == S_IDLE) begin
      rd_free <= free_stack[free_count[NW-1:0] - 1'b1];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_GRP) begin
      rd_head <= head[g];
      rd_tail <= tail[g];
    end
    if (state == S_FIN) begin
      if (enq_ok) begin
        tail[g] <= rd_free;
        if (!active[g]) begin
          head[g] <= rd_free;
        end
      end else if (deq_ok && !deq_last) begin
        head[g] <= rd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_NODE) begin
      rd_value <= node_value[rd_head];
      rd_next <= node_next[rd_head];
    end
    if (state == S_FIN && enq_ok) begin
      node_value[rd_free] <= cw.element;
      if (active[g]) begin
        node_next[rd_tail] <= rd_free;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      init_ptr <= '0;
      free_count <= (NW+1)'(NodeCapacity);
      active <= '0;
      oh <= '0;
      ot <= '0;
      ocount <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!init_ptr[NW]) begin
        init_ptr <= init_ptr + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cw <= cmd_word;
            state <= S_GRP;
          end
        end
        S_GRP: begin
          state <= S_NODE;
        end
        S_NODE: begin
          state <= S_FIN;
        end
        S_FIN: begin
          state <= S_IDLE;
          done <= 1'b1;
          res <= res_next;
          if (enq_ok) begin
            free_count <= free_count - 1'b1;
            if (!active[g]) begin
              active[g] <= 1'b1;
              ot <= ot + 1'b1;
              ocount <= ocount + 1'b1;
            end
          end else if (deq_ok) begin
            free_count <= free_count + 1'b1;
            // Retire the group once its last node leaves
            if (deq_last) begin
              active[g] <= 1'b0;
              oh <= oh + 1'b1;
              ocount <= ocount - 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GFQ_ASSERT_ALWAYS(a_count_range, clk, rst, ocount <= (GW+1)'(GroupCount))
  `GFQ_ASSERT_ALWAYS(a_free_range, clk, rst, free_count <= (NW+1)'(NodeCapacity))
  `GFQ_ASSERT_ALWAYS(a_state_onehot, clk, rst, $onehot(state))
  `GFQ_ASSERT_IMPL(a_done_fin, clk, rst, done, $past(state) == S_FIN)
  `GFQ_ASSERT_IMPL(a_deq_valid, clk, rst, done && res.out_valid, res.status == ST_OK)
endmodule
`default_nettype wire

>>> rtl/grouped_fifo_queue.sv
// ---------------------------------------------------------------------------
// grouped_fifo_queue
// Team queue: elements of one group wait together, groups in FIFO order.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  carries a command word (command, element, group_id).
//   out_ch returns one result word per command (out_element, out_valid,
//   status). Words move when valid and ready are both high.
//   A command is accepted on the edge where the map, order and free-list
//   reads land; the core then reads the group head/tail in S_GRP and the
//   node in S_NODE, and in S_FIN it writes back and registers the result.
//   The result word then moves into the out_ch output register.
//   One command is in flight at a time; in_ch.ready rises again once the
//   result is taken, so throughput is set by the chain of dependent
//   memory reads and the output handshake.
//   After reset the map is cleared over all 1024 entries and the free
//   list is loaded in parallel; in_ch.ready stays low meanwhile.
//   When out_ch is stalled the result holds in its output register and
//   no new command is taken until it is delivered.
// ---------------------------------------------------------------------------
`default_nettype none
module grouped_fifo_queue
  import gfq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  gfq_if.sink       in_ch,
  gfq_if.source     out_ch
);
  in_word_t  iw;
  out_word_t res;
  logic busy, done, pending, start;
  logic [GW:0] map_data;

  assign iw = in_word_t'(in_ch.data);
  assign in_ch.ready = !busy && !pending && !out_ch.valid;
  assign start = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (start) begin
        pending <= 1'b1;
      end else if (done) begin
        pending <= 1'b0;
      end
      if (done) begin
        out_ch.valid <= 1'b1;
        out_ch.data <= res;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  gfq_map u_map (
    .clk(clk), .rst(rst),
    .rd_en(start && iw.command == CMD_ENQ), .rd_addr(iw.element),
    .rd_data(map_data),
    .wr_en(start && iw.command == CMD_BIND),
    .wr_addr(iw.element), .wr_data({1'b1, iw.group_id}),
    .busy(busy)
  );

  gfq_core u_core (
    .clk(clk), .rst(rst), .start(start), .cmd_word(iw),
    .map_data(map_data), .res(res), .done(done)
  );
endmodule
`default_nettype wire

>>> tb/gfq_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gfq_checker
// Watches both channels of the team queue, models groups and their order,
// and compares every result word with the predicted one.
// ---------------------------------------------------------------------------
`default_nettype none
module gfq_checker
  import gfq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire logic [$bits(in_word_t)-1:0] in_data,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire logic [$bits(out_word_t)-1:0] out_data,
  output int        fail_count,
  output int        pending,
  output int        deq_ok_count,
  output int        full_count
);
  // element -> group binding
  logic          bound [ElementSpace];
  logic [GW-1:0] bound_group [ElementSpace];
  // waiting elements per group, and the order of active groups
  logic [EW-1:0] group_members [GroupCount][$];
  logic [GW-1:0] group_order [$];
  int            waiting_total;
  out_word_t     expected_results [$];

  function automatic out_word_t predict_result(in_word_t w);
    out_word_t r;
    logic [GW-1:0] g;
    r = '0;
    r.status = ST_OK;
    case (cmd_t'(w.command))
      CMD_BIND: begin
        bound[w.element] = 1'b1;
        bound_group[w.element] = w.group_id;
      end
      CMD_ENQ: begin
        if (!bound[w.element]) begin
          r.status = ST_UNASSIGNED;
        end else if (waiting_total >= NodeCapacity) begin
          r.status = ST_FULL;
        end else begin
          g = bound_group[w.element];
          if (group_members[g].size() == 0) group_order.push_back(g);
          group_members[g].push_back(w.element);
          waiting_total++;
        end
      end
      CMD_DEQ: begin
        if (group_order.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          g = group_order[0];
          r.out_element = group_members[g].pop_front();
          r.out_valid = 1'b1;
          waiting_total--;
          if (group_members[g].size() == 0) void'(group_order.pop_front());
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_word_t got, want;
    if (rst) begin
      for (int i = 0; i < ElementSpace; i++) bound[i] = 1'b0;
      for (int i = 0; i < GroupCount; i++) group_members[i].delete();
      group_order.delete();
      expected_results.delete();
      waiting_total = 0;
      fail_count = 0;
      deq_ok_count = 0;
      full_count = 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_result(in_word_t'(in_data)));
      if (out_valid && out_ready) begin
        got = out_word_t'(out_data);
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", got);
        end else begin
          want = expected_results.pop_front();
          if (want.out_valid) deq_ok_count++;
          if (want.status == ST_FULL) full_count++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected elem %0d valid %0d status %0d, got %0d %0d %0d",
                       want.out_element, want.out_valid, want.status,
                       got.out_element, got.out_valid, got.status);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives bind/enqueue/dequeue words into the team queue with bursty input
// and a stalling output; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
`default_nettype none
module testbench
  import gfq_pkg::*;
();
  localparam int InW = $bits(in_word_t);

  logic clk;
  logic rst;
  int   cycle_count;
  int   fail_count, pending, deq_ok_count, full_count;
  int   sent_count;
  logic hold_off;
  logic [EW-1:0] hot_elems [16];

  gfq_if #(.W($bits(in_word_t)))  in_ch ();
  gfq_if #(.W($bits(out_word_t))) out_ch ();

  grouped_fifo_queue dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  gfq_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .pending(pending),
    .deq_ok_count(deq_ok_count), .full_count(full_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Limit: map clear plus ~1950 words, each with gap, processing and stall, several times over.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stalls, some clean stretches, one long hold-off.
  initial begin
    int mode;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else begin
        mode = (cycle_count / 500) % 3;
        if (mode == 0) out_ch.ready <= 1'b1;
        else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
        else out_ch.ready <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (sent_count >= 300);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  // Offer one word and hold it until accepted; gaps come between bursts.
  task automatic send_word(cmd_t c, logic [EW-1:0] e, logic [GW-1:0] g);
    in_word_t w;
    w.command = c;
    w.element = e;
    w.group_id = g;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= InW'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic random_word(int deq_weight);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) send_word(CMD_BIND, hot_elems[4'($urandom_range(0, 15))], GW'($urandom));
    else if (pick < 10) send_word(CMD_BIND, EW'($urandom), GW'($urandom));
    else if (pick < 11) send_word(CMD_NOP, EW'($urandom), GW'($urandom));
    else if (pick < 100 - deq_weight) begin
      if ($urandom_range(0, 19) == 0) send_word(CMD_ENQ, EW'($urandom), GW'($urandom));
      else send_word(CMD_ENQ, hot_elems[4'($urandom_range(0, 15))], GW'($urandom));
    end else send_word(CMD_DEQ, EW'($urandom), GW'($urandom));
    idle_gap();
  endtask

  initial begin
    rst = 1'b1;
    sent_count = 0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty dequeue, unbound enqueue, extremes, rebinding, nop
    send_word(CMD_DEQ, 10'h3ff, 6'h3f);
    send_word(CMD_ENQ, 10'd0, 6'd0);
    send_word(CMD_ENQ, 10'h3ff, 6'h3f);
    send_word(CMD_BIND, 10'd0, 6'd0);
    send_word(CMD_BIND, 10'h3ff, 6'h3f);
    send_word(CMD_BIND, 10'h155, 6'h2a);
    send_word(CMD_BIND, 10'h2aa, 6'h15);
    send_word(CMD_ENQ, 10'h3ff, 6'd0);
    send_word(CMD_ENQ, 10'd0, 6'd0);
    send_word(CMD_ENQ, 10'h3ff, 6'd0);
    send_word(CMD_ENQ, 10'h155, 6'd0);
    send_word(CMD_BIND, 10'h3ff, 6'd0);
    send_word(CMD_ENQ, 10'h3ff, 6'd0);
    send_word(CMD_ENQ, 10'h2aa, 6'd0);
    send_word(CMD_NOP, 10'h3ff, 6'h3f);
    for (int i = 0; i < 8; i++) send_word(CMD_DEQ, 10'd0, 6'd0);

    for (int i = 0; i < 16; i++) begin
      hot_elems[i] = EW'($urandom);
      send_word(CMD_BIND, hot_elems[i], GW'($urandom));
    end

    // random: phases of growth, drain and mixed traffic
    for (int i = 0; i < 780; i++) begin
      case ((i / 150) % 3)
        0: random_word(15);
        1: random_word(60);
        default: random_word(35);
      endcase
    end

    // fill storage to full, check the refusal, then take some back out
    for (int i = 0; i < NodeCapacity + 4; i++) begin
      send_word(CMD_ENQ, hot_elems[4'(i % 16)], GW'($urandom));
    end
    for (int i = 0; i < 100; i++) send_word(CMD_DEQ, EW'($urandom), GW'($urandom));
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d words: %0d dequeued elements, %0d full refusals", sent_count,
             deq_ok_count, full_count);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/gfq_pkg.sv
rtl/gfq_if.sv
rtl/gfq_map.sv
rtl/gfq_core.sv
rtl/grouped_fifo_queue.sv
tb/gfq_checker.sv
tb/testbench.sv
